// File: hdl/vcsd_pkg.sv
// package for the vehicle CAN signal decoder: payload types, frame ids,
// register indexes and the brightness curve table
// no dependencies
package vcsd_pkg;

   localparam int FRAME_BYTES = 8;

   localparam logic [10:0] ID_LIGHTS  = 11'h3F5;
   localparam logic [10:0] ID_DOOR_R  = 11'h103;
   localparam logic [10:0] ID_DOOR_L  = 11'h102;
   localparam logic [10:0] ID_STATUS  = 11'h2E1;
   localparam logic [10:0] ID_GEAR    = 11'h118;
   localparam logic [10:0] ID_ASSIST  = 11'h399;
   localparam logic [10:0] ID_CONTROL = 11'h273;

   localparam logic BUS_VEHICLE = 1'b0;
   localparam logic BUS_CHASSIS = 1'b1;

   localparam logic [7:0]  OPEN_BIT       = 8'h20;
   localparam logic [2:0]  GEAR_INVALID   = 3'd7;
   localparam logic [15:0] PULL_GAP_RESET = 16'd1500;
   localparam logic [15:0] HOLD_MIN_RESET = 16'd500;
   localparam logic [7:0]  PULL_MAX       = 8'd255;
   localparam logic [7:0]  PULL_OPEN      = 8'd2;

   localparam int BRIGHT_OFFSET = 'h0B;
   localparam int BRIGHT_TOP    = 'hC8;
   localparam int BRIGHT_SPAN   = BRIGHT_TOP - BRIGHT_OFFSET;
   localparam int T_FLOOR       = 34;
   localparam int T_CEIL        = 255;

   typedef enum logic [1:0] {
      REG_GESTURE  = 2'd0,
      REG_PULL_GAP = 2'd1,
      REG_HOLD_MIN = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic        bus_sel;
      logic [10:0] frame_id;
      logic [3:0]  data_len;
      logic [7:0]  byte_0;
      logic [7:0]  byte_1;
      logic [7:0]  byte_2;
      logic [7:0]  byte_3;
      logic [7:0]  byte_4;
      logic [7:0]  byte_5;
      logic [7:0]  byte_6;
      logic [7:0]  byte_7;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [3:0]  lamp_flags;
      logic        display_on;
      logic [7:0]  brightness;
      logic [8:0]  assist_flags;
      logic [3:0]  door_open;
      logic [1:0]  handle_pull;
      logic [2:0]  gear_code;
      logic        frunk_open;
      logic        cmd_valid;
      logic [63:0] cmd_frame;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  reg_index;
      logic [15:0] write_data;
   } csr_type;

   typedef struct packed {
      logic        gesture_enable;
      logic [15:0] pull_gap_ms;
      logic [15:0] hold_min_ms;
   } cfg_type;

   typedef struct packed {
      logic [3:0]      lamp;
      logic            display;
      logic [7:0]      bright;
      logic [8:0]      assist;
      logic [3:0]      door;
      logic [1:0]      handle;
      logic [2:0]      gear;
      logic            frunk;
      logic [7:0][7:0] control;
      logic            held;
      logic [7:0]      pull_count;
      logic [31:0]     last_pull_time;
      logic [31:0]     last_open_time;
   } sig_type;

   typedef logic [7:0] bright_lut_type [256];

   // raw brightness byte to display level, including off and floor codes
   function automatic bright_lut_type build_bright_lut();
      bright_lut_type lut;
      int t;
      for (int r = 0; r < 256; r++) begin
         if (r < BRIGHT_OFFSET) begin
            t = T_FLOOR;
         end else begin
            t = ((r - BRIGHT_OFFSET) * 255) / BRIGHT_SPAN;
            if (t < T_FLOOR) t = T_FLOOR;
            if (t > T_CEIL) t = T_CEIL;
         end
         lut[r] = 8'(((t - T_FLOOR) * 250) / 221 + 5);
      end
      lut[0] = 8'd0;
      lut[BRIGHT_OFFSET] = 8'd0;
      return lut;
   endfunction

   localparam bright_lut_type BRIGHT_LUT = build_bright_lut();

endpackage

// File: hdl/vcsd_chan_if.sv
// valid/ready channel carrying one item of a chosen payload type
// depends on nothing; payload types come from vcsd_pkg at instantiation
interface vcsd_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/vcsd_decode.sv
// frame dispatch and signal update for one item, plus the handle gesture
// depends on vcsd_pkg
module vcsd_decode
   import vcsd_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_BYTES
)
(
   input  req_type     frame,
   input  sig_type     st,
   input  cfg_type     cfg,
   output sig_type     st_next,
   output logic        cmd_valid,
   output logic [63:0] cmd_frame
);

   logic [7:0][7:0] raw;
   logic [7:0][7:0] d;
   logic [3:0]      len_c;
   logic [31:0]     now;
   logic [31:0]     dt;
   logic            gap_hit;
   logic            hold_hit;
   logic            took_now;
   logic            open_lt;
   logic [1:0]      bl;
   logic [1:0]      br;
   logic [3:0]      ap;
   logic [3:0]      ho;
   sig_type         s;

   assign raw = {frame.byte_7, frame.byte_6, frame.byte_5, frame.byte_4,
                 frame.byte_3, frame.byte_2, frame.byte_1, frame.byte_0};
   assign now = frame.time_ms;
   assign len_c = (frame.data_len > 4'(FRAME_LEN)) ? 4'(FRAME_LEN) : frame.data_len;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         d[i] = (4'(i) < len_c) ? raw[i] : 8'd0;
      end
   end

   assign bl = d[0][5:4];
   assign br = d[0][7:6];
   assign ap = d[0][3:0];
   assign ho = d[5][5:2];

   assign dt       = now - st.last_pull_time;
   assign gap_hit  = dt > {16'd0, cfg.pull_gap_ms};
   assign hold_hit = dt > {16'd0, cfg.hold_min_ms};

   always_comb begin
      s = st;
      took_now = 1'b0;
      cmd_valid = 1'b0;
      cmd_frame = 64'd0;

      // dispatch
      if (frame.bus_sel == BUS_VEHICLE) begin
         unique case (frame.frame_id)
            ID_LIGHTS: begin
               s.lamp = d[0][3:0];
               s.display = (d[2] != 8'd0);
               s.bright = BRIGHT_LUT[d[2]];
            end
            ID_DOOR_R: begin
               s.door[0] = d[0][0];
               s.door[2] = d[0][4];
               s.handle[0] = d[1][2];
            end
            ID_DOOR_L: begin
               s.door[1] = d[0][0];
               s.door[3] = d[0][4];
               s.handle[1] = d[1][2];
            end
            ID_STATUS: begin
               if (d[0][2:0] == 3'd0) s.frunk = (d[0][6:3] != 4'd2);
            end
            ID_GEAR: s.gear = d[2][7:5];
            default: ;
         endcase
      end else begin
         unique case (frame.frame_id)
            ID_ASSIST: begin
               s.assist = {ho > 4'd3, ho > 4'd2, ho != 4'd0, ho == 4'd1,
                           (ap == 4'd3) || (ap == 4'd4) || (ap == 4'd5),
                           br > 2'd1, bl > 2'd1, br != 2'd0, bl != 2'd0};
            end
            ID_CONTROL: begin
               for (int i = 0; i < 8; i++) begin
                  if (4'(i) < len_c) s.control[i] = d[i];
               end
            end
            default: ;
         endcase
      end

      // handle gesture
      if (cfg.gesture_enable) begin
         if (s.handle != 2'd0) begin
            if (!st.held) begin
               s.held = 1'b1;
               if (gap_hit) s.pull_count = 8'd0;
               s.last_pull_time = now;
               took_now = 1'b1;
            end
         end else if (st.held) begin
            if (hold_hit) begin
               if (st.pull_count != PULL_MAX) s.pull_count = st.pull_count + 8'd1;
            end else begin
               s.pull_count = 8'd0;
            end
            s.held = 1'b0;
         end
         open_lt = took_now ? (st.last_open_time < now)
                            : (st.last_open_time < st.last_pull_time);
         if (s.held && (s.pull_count == PULL_OPEN) && open_lt) begin
            s.last_open_time = now;
            s.pull_count = 8'd0;
            if ((s.control[0] != 8'd0) && !s.frunk) begin
               cmd_valid = 1'b1;
               cmd_frame = s.control | {56'd0, OPEN_BIT};
            end
         end
      end else begin
         open_lt = 1'b0;
      end
   end

   assign st_next = s;

endmodule

// File: hdl/vehicle_can_signal_decoder_top.sv
// top level of the vehicle CAN signal decoder: input register, signal state,
// result register and configuration registers; depends on vcsd_pkg,
// vcsd_chan_if and vcsd_decode
//
// One item is one received CAN frame; each item yields exactly one result item
// holding the signals after the update and any front trunk command. Items are
// taken every cycle while the result side keeps up: a frame is held in the
// input register and is decoded by a single pass of logic into the signal
// state and the result register, so throughput is one item per cycle.
// Configuration is written through the csr channel, which is always ready;
// no clearing pass is needed after reset.
module vehicle_can_signal_decoder_top
   import vcsd_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_BYTES
)
(
   input logic         clock,
   input logic         reset,
   vcsd_chan_if.sink   req_chan,
   vcsd_chan_if.source rsp_chan,
   vcsd_chan_if.sink   csr_chan
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   sig_type     st_ff, st_in;
   cfg_type     cfg_ff, cfg_in;
   sig_type     st_next;
   logic        cmd_valid;
   logic [63:0] cmd_frame;
   logic        adv;
   logic        req_take;
   csr_type     csr;

   assign adv      = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready  = !in_valid_ff || adv;
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
   assign csr = csr_chan.payload;

   vcsd_decode #(
      .FRAME_LEN (FRAME_LEN)
   ) u_decode (
      .frame     (in_ff),
      .st        (st_ff),
      .cfg       (cfg_ff),
      .st_next   (st_next),
      .cmd_valid (cmd_valid),
      .cmd_frame (cmd_frame)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (adv) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (adv) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;

      st_in = adv ? st_next : st_ff;

      rsp_in = rsp_ff;
      if (adv) begin
         rsp_in.lamp_flags   = st_next.lamp;
         rsp_in.display_on   = st_next.display;
         rsp_in.brightness   = st_next.bright;
         rsp_in.assist_flags = st_next.assist;
         rsp_in.door_open    = st_next.door;
         rsp_in.handle_pull  = st_next.handle;
         rsp_in.gear_code    = st_next.gear;
         rsp_in.frunk_open   = st_next.frunk;
         rsp_in.cmd_valid    = cmd_valid;
         rsp_in.cmd_frame    = cmd_frame;
      end

      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr.reg_index)
            REG_GESTURE:  cfg_in.gesture_enable = csr.write_data[0];
            REG_PULL_GAP: cfg_in.pull_gap_ms = csr.write_data;
            REG_HOLD_MIN: cfg_in.hold_min_ms = csr.write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.gesture_enable <= 1'b0;
         cfg_ff.pull_gap_ms    <= PULL_GAP_RESET;
         cfg_ff.hold_min_ms    <= HOLD_MIN_RESET;
         st_ff <= '{gear: GEAR_INVALID, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff <= cfg_in;
         st_ff  <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_ff <= req_chan.payload;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_adv_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid_ff)
      else $error("decoded item did not reach the result register");

   a_no_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.cmd_valid |-> rsp_ff.cmd_frame == 64'd0)
      else $error("command frame nonzero without command");

   a_cmd_open_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.cmd_valid |-> rsp_ff.cmd_frame[5] && !rsp_ff.frunk_open)
      else $error("command without open bit or with trunk open");

   a_gesture_frozen: assert property (@(posedge clock) disable iff (reset)
      !cfg_ff.gesture_enable |=> $stable(st_ff.held) && $stable(st_ff.pull_count))
      else $error("gesture state moved while disabled");
`endif

endmodule
